// ===== hw/rtl/rntvl_pkg.sv =====
// shared types and constants for the raft node
package rntvl_pkg;
  localparam int unsigned LogDepth = 64;
  localparam int unsigned MaxNodes = 16;
  localparam int unsigned IdxW = $clog2(LogDepth);
  localparam int unsigned PosW = 7;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned QDepth = 2;
  localparam logic [4:0] NoVote = 5'd16;

  typedef enum logic [2:0] {
    CmdAppend = 3'd0, CmdVote = 3'd1, CmdHigher = 3'd2, CmdElect = 3'd3,
    CmdLeader = 3'd4, CmdCommit = 3'd5, CmdApply = 3'd6, CmdTick = 3'd7
  } cmd_e;

  localparam logic [1:0] RoleFollower = 2'd0;
  localparam logic [1:0] RoleCandidate = 2'd1;
  localparam logic [1:0] RoleLeader = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgOwnNode = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgHeartbeat = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgElecMin = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgElecMax = 2'd3;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] event_tag;
    logic [47:0] stamp_ms;
    logic [1:0]  entry_kind;
    logic [31:0] peer_term;
    logic [3:0]  peer_node;
    logic [6:0]  commit_target;
    logic [9:0]  jitter;
  } req_t;

  typedef struct packed {
    logic        accepted;
    logic [6:0]  log_position;
    logic [31:0] term_now;
    logic [1:0]  role;
    logic        heartbeat_expired;
    logic        election_expired;
    logic [31:0] out_event;
    logic [47:0] out_stamp;
    logic [1:0]  out_kind;
    logic        last;
  } rsp_t;

  // classified request from front to back
  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] event_tag;
    logic [47:0] stamp_ms;
    logic [1:0]  entry_kind;
    logic [31:0] peer_term;
    logic [3:0]  peer_node;
    logic [6:0]  commit_target;
    logic [9:0]  jitter;
    logic        target_ok;
  } op_t;
endpackage

// ===== hw/rtl/rntvl_req_if.sv =====
// request and response channel interfaces
interface rntvl_req_if import rntvl_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rntvl_rsp_if import rntvl_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/rntvl_front.sv =====
// front end: accepts requests, classifies them, queues them
module rntvl_front import rntvl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  rntvl_req_if.sink req,
  output logic op_valid_o,
  output op_t  op_o,
  input  logic op_ready_i
);
  op_t q_q [QDepth];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, pop;
  op_t op_in;

  always_comb begin
    op_in.cmd = cmd_e'(req.data.command);
    op_in.event_tag = req.data.event_tag;
    op_in.stamp_ms = req.data.stamp_ms;
    op_in.entry_kind = req.data.entry_kind;
    op_in.peer_term = req.data.peer_term;
    op_in.peer_node = req.data.peer_node;
    op_in.commit_target = req.data.commit_target;
    op_in.jitter = req.data.jitter;
    op_in.target_ok = (req.data.commit_target != '0)
                   && (req.data.commit_target <= PosW'(LogDepth));
  end

  assign req.ready = (cnt_q != 2'(QDepth));
  assign push = req.valid && req.ready;
  assign op_valid_o = (cnt_q != '0);
  assign op_o = q_q[rp_q];
  assign pop = op_valid_o && op_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) q_q[wp_q] <= op_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
endmodule

// ===== hw/rtl/rntvl_back.sv =====
// back end: node state, log memory, timeout divider and result register
module rntvl_back import rntvl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic [3:0]  own_node_i,
  input  logic [15:0] heartbeat_limit_i,
  input  logic [15:0] election_min_i,
  input  logic [15:0] election_max_i,
  input  logic op_valid_i,
  input  op_t  op_i,
  output logic op_ready_o,
  rntvl_rsp_if.source rsp
);
  typedef enum logic [2:0] {
    StIdle, StRead, StCheck, StApplyRd, StApplyOut, StDiv, StOut
  } state_e;

  state_e st_q;
  op_t op_q;
  logic [31:0] term_q;
  logic [4:0] vote_q;
  logic [1:0] role_q;
  logic [6:0] count_q, commit_q, applied_q;
  logic [31:0] elapsed_q;
  logic [31:0] mem_term [LogDepth];
  logic [81:0] mem_data [LogDepth];
  logic [31:0] rd_term_q;
  logic [81:0] rd_data_q;
  logic [IdxW-1:0] rd_addr;
  logic [9:0] rem_q;
  logic [15:0] span_q;
  logic [3:0] div_cnt_q;
  logic [9:0] cand;
  logic [9:0] rem_d;
  logic apply_more;
  logic hb_hit, el_hit;
  rsp_t rsp_q;
  logic rsp_valid_q;

  assign rsp.valid = rsp_valid_q;
  assign rsp.data = rsp_q;
  assign op_ready_o = (st_q == StIdle) && !rsp_valid_q;

  always_comb begin
    rd_addr = applied_q[IdxW-1:0];
    if (st_q == StRead) rd_addr = IdxW'(op_q.commit_target - 7'd1);
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && op_valid_i && op_ready_o && op_i.cmd == CmdAppend
        && role_q == RoleLeader && count_q < PosW'(LogDepth)) begin
      mem_term[count_q[IdxW-1:0]] <= term_q;
      mem_data[count_q[IdxW-1:0]] <= {op_i.event_tag, op_i.stamp_ms, op_i.entry_kind};
    end
    rd_term_q <= mem_term[rd_addr];
    rd_data_q <= mem_data[rd_addr];
  end

  // restoring division, one jitter bit per cycle
  always_comb begin
    cand = {rem_q[8:0], op_q.jitter[4'd9 - div_cnt_q]};
    if ({6'd0, cand} >= span_q) rem_d = cand - span_q[9:0];
    else rem_d = cand;
  end

  assign apply_more = (applied_q + 7'd1 < commit_q) && (applied_q + 7'd1 < count_q);
  assign hb_hit = elapsed_q > {16'd0, heartbeat_limit_i};
  assign el_hit = (election_max_i > election_min_i)
                ? (elapsed_q > ({16'd0, election_min_i} + {22'd0, rem_q}))
                : (elapsed_q > {16'd0, election_min_i});

  function automatic rsp_t mk(logic acc, logic [6:0] pos, logic [31:0] t, logic [1:0] r,
                              logic l);
    rsp_t x;
    x = '0;
    x.accepted = acc;
    x.log_position = pos;
    x.term_now = t;
    x.role = r;
    x.last = l;
    return x;
  endfunction

  function automatic rsp_t mk_ext(rsp_t b, logic hb, logic el, logic [81:0] d);
    rsp_t x;
    x = b;
    x.heartbeat_expired = hb;
    x.election_expired = el;
    x.out_event = d[81:50];
    x.out_stamp = d[49:2];
    x.out_kind = d[1:0];
    return x;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      op_q <= '0;
      term_q <= '0;
      vote_q <= NoVote;
      role_q <= RoleFollower;
      count_q <= '0;
      commit_q <= '0;
      applied_q <= '0;
      elapsed_q <= '0;
      rem_q <= '0;
      span_q <= '0;
      div_cnt_q <= '0;
      rsp_q <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (rsp_valid_q && rsp.ready && st_q != StApplyOut) rsp_valid_q <= 1'b0;
      unique case (st_q)
        StIdle: begin
          if (op_valid_i && op_ready_o) begin
            op_q <= op_i;
            unique case (op_i.cmd)
              CmdAppend: begin
                if (role_q == RoleLeader && count_q < PosW'(LogDepth)) begin
                  count_q <= count_q + 7'd1;
                  rsp_q <= mk(1'b1, count_q + 7'd1, term_q, role_q, 1'b1);
                end else begin
                  rsp_q <= mk(1'b0, count_q, term_q, role_q, 1'b1);
                end
                rsp_valid_q <= 1'b1;
              end
              CmdVote: begin
                if (op_i.peer_term > term_q) begin
                  term_q <= op_i.peer_term;
                  role_q <= RoleFollower;
                  vote_q <= {1'b0, op_i.peer_node};
                  elapsed_q <= '0;
                  rsp_q <= mk(1'b1, commit_q, op_i.peer_term, RoleFollower, 1'b1);
                end else if (op_i.peer_term == term_q
                             && (vote_q == NoVote || vote_q == {1'b0, op_i.peer_node})) begin
                  vote_q <= {1'b0, op_i.peer_node};
                  elapsed_q <= '0;
                  rsp_q <= mk(1'b1, commit_q, term_q, role_q, 1'b1);
                end else begin
                  rsp_q <= mk(1'b0, commit_q, term_q, role_q, 1'b1);
                end
                rsp_valid_q <= 1'b1;
              end
              CmdHigher: begin
                if (op_i.peer_term > term_q) begin
                  term_q <= op_i.peer_term;
                  role_q <= RoleFollower;
                  vote_q <= NoVote;
                  rsp_q <= mk(1'b1, commit_q, op_i.peer_term, RoleFollower, 1'b1);
                end else begin
                  rsp_q <= mk(1'b0, commit_q, term_q, role_q, 1'b1);
                end
                rsp_valid_q <= 1'b1;
              end
              CmdElect: begin
                if (term_q != '1) begin
                  term_q <= term_q + 32'd1;
                  role_q <= RoleCandidate;
                  vote_q <= {1'b0, own_node_i};
                  elapsed_q <= '0;
                  rsp_q <= mk(1'b1, commit_q, term_q + 32'd1, RoleCandidate, 1'b1);
                end else begin
                  rsp_q <= mk(1'b0, commit_q, term_q, role_q, 1'b1);
                end
                rsp_valid_q <= 1'b1;
              end
              CmdLeader: begin
                role_q <= RoleLeader;
                rsp_q <= mk(1'b1, commit_q, term_q, RoleLeader, 1'b1);
                rsp_valid_q <= 1'b1;
              end
              CmdCommit: st_q <= StRead;
              CmdApply: begin
                if (applied_q < commit_q && applied_q < count_q) begin
                  st_q <= StApplyRd;
                end else begin
                  rsp_q <= mk(1'b0, applied_q, term_q, role_q, 1'b1);
                  rsp_valid_q <= 1'b1;
                end
              end
              CmdTick: begin
                if (elapsed_q != '1) elapsed_q <= elapsed_q + 32'd1;
                rem_q <= '0;
                span_q <= election_max_i - election_min_i;
                div_cnt_q <= '0;
                st_q <= StDiv;
              end
              default: st_q <= StIdle;
            endcase
          end
        end
        StRead: st_q <= StCheck;
        StCheck: begin
          if (op_q.target_ok && op_q.commit_target > commit_q
              && op_q.commit_target <= count_q && rd_term_q == term_q) begin
            commit_q <= op_q.commit_target;
            rsp_q <= mk(1'b1, op_q.commit_target, term_q, role_q, 1'b1);
          end else begin
            rsp_q <= mk(1'b0, commit_q, term_q, role_q, 1'b1);
          end
          rsp_valid_q <= 1'b1;
          st_q <= StIdle;
        end
        StApplyRd: st_q <= StApplyOut;
        StApplyOut: begin
          if (!rsp_valid_q || rsp.ready) begin
            rsp_q <= mk_ext(mk(1'b1, applied_q + 7'd1, term_q, role_q, !apply_more),
                            1'b0, 1'b0, rd_data_q);
            applied_q <= applied_q + 7'd1;
            rsp_valid_q <= 1'b1;
            if (apply_more) st_q <= StApplyRd;
            else st_q <= StIdle;
          end
        end
        StDiv: begin
          rem_q <= rem_d;
          div_cnt_q <= div_cnt_q + 4'd1;
          if (div_cnt_q == 4'd9) st_q <= StOut;
        end
        StOut: begin
          rsp_q <= mk_ext(mk(1'b0, commit_q, term_q, role_q, 1'b1), hb_hit, el_hit, '0);
          rsp_valid_q <= 1'b1;
          st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end
endmodule

// ===== hw/rtl/raft_node_term_vote_log.sv =====
// raft node top level: configuration registers, front end and back end
// results: most commands register their result on accept; commit passes through the read
// and check states, tick through the remainder unit (one jitter bit per cycle) and an
// output state, and apply alternates a read state and an output state for each entry
// throughput: one request at a time in the back end, a two-entry queue in front
// reset: asynchronous active low; configuration returns to 0, 50, 150, 300
module raft_node_term_vote_log import rntvl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  rntvl_req_if.sink req,
  rntvl_rsp_if.source rsp
);
  logic [3:0] own_q;
  logic [15:0] hb_q, emin_q, emax_q;
  logic op_valid, op_ready;
  op_t op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q <= '0;
      hb_q <= 16'd50;
      emin_q <= 16'd150;
      emax_q <= 16'd300;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgOwnNode: own_q <= cfg_data_i[3:0];
        CfgHeartbeat: hb_q <= cfg_data_i;
        CfgElecMin: emin_q <= cfg_data_i;
        CfgElecMax: emax_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rntvl_front u_front (
    .clk_i, .rst_ni, .req,
    .op_valid_o(op_valid), .op_o(op), .op_ready_i(op_ready)
  );

  rntvl_back u_back (
    .clk_i, .rst_ni,
    .own_node_i(own_q), .heartbeat_limit_i(hb_q),
    .election_min_i(emin_q), .election_max_i(emax_q),
    .op_valid_i(op_valid), .op_i(op), .op_ready_o(op_ready), .rsp
  );
endmodule

// ===== hw/rtl/rntvl_checker.sv =====
// port-level checks for the raft node
module rntvl_checker import rntvl_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp_data
);
  a_role_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> rsp_data.role != 2'd3) else $error("bad role");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> $stable(rsp_data)) else $error("result changed");
  a_unapplied_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_data.accepted |-> rsp_data.out_event == '0)
    else $error("event on non-apply");
  a_nonlast_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_data.last |-> rsp_data.accepted) else $error("open apply not accepted");
endmodule

bind raft_node_term_vote_log rntvl_checker u_chk (
  .clk_i, .rst_ni, .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);

// ===== tb/sv/tb_raft_node_term_vote_log_chk.sv =====
// response checker for the raft node: tracks node state and compares every response
`timescale 1ns / 1ps
module tb_raft_node_term_vote_log_chk import rntvl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  rntvl_req_if               req,
  rntvl_rsp_if               rsp,
  output int unsigned        fails_o,
  output int unsigned        pending_o,
  output int unsigned        responses_o,
  output logic [31:0]        term_o,
  output logic [6:0]         log_count_o,
  output logic [6:0]         commit_o
);
  logic [3:0]  own_id;
  logic [15:0] hb_limit, elec_min, elec_max;
  logic [31:0] term_q;
  logic [4:0]  voted_for;
  logic [1:0]  role_q;
  logic [31:0] log_term [LogDepth];
  logic [31:0] log_event [LogDepth];
  logic [47:0] log_stamp [LogDepth];
  logic [1:0]  log_kind [LogDepth];
  logic [6:0]  log_count, commit_idx, applied_idx;
  logic [31:0] elapsed;
  rsp_t        expected_rsp [$];

  assign term_o = term_q;
  assign log_count_o = log_count;
  assign commit_o = commit_idx;

  function automatic void queue_rsp(rsp_t r);
    expected_rsp.insert(expected_rsp.size(), r);
  endfunction

  function automatic rsp_t node_rsp(logic acc, logic [6:0] pos);
    rsp_t r;
    r = '0;
    r.accepted = acc;
    r.log_position = pos;
    r.term_now = term_q;
    r.role = role_q;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic void take_term(logic [31:0] t);
    term_q = t;
    voted_for = NoVote;
    role_q = RoleFollower;
  endfunction

  function automatic void advance_node(req_t r);
    rsp_t        o;
    logic        acc;
    logic [31:0] limit;
    int          n;
    acc = 1'b0;
    case (cmd_e'(r.command))
      CmdAppend: begin
        if (role_q == RoleLeader && log_count < LogDepth) begin
          log_term[log_count[5:0]] = term_q;
          log_event[log_count[5:0]] = r.event_tag;
          log_stamp[log_count[5:0]] = r.stamp_ms;
          log_kind[log_count[5:0]] = r.entry_kind;
          log_count++;
          acc = 1'b1;
        end
        queue_rsp(node_rsp(acc, log_count));
        return;
      end
      CmdVote: begin
        if (r.peer_term >= term_q) begin
          if (r.peer_term > term_q) take_term(r.peer_term);
          if (voted_for == NoVote || voted_for == {1'b0, r.peer_node}) begin
            voted_for = {1'b0, r.peer_node};
            elapsed = 0;
            acc = 1'b1;
          end
        end
      end
      CmdHigher: begin
        if (r.peer_term > term_q) begin
          take_term(r.peer_term);
          acc = 1'b1;
        end
      end
      CmdElect: begin
        if (term_q != 32'hffff_ffff) begin
          term_q++;
          role_q = RoleCandidate;
          voted_for = {1'b0, own_id};
          elapsed = 0;
          acc = 1'b1;
        end
      end
      CmdLeader: begin
        role_q = RoleLeader;
        acc = 1'b1;
      end
      CmdCommit: begin
        if (r.commit_target > commit_idx && r.commit_target <= log_count &&
            r.commit_target != 0 && log_term[r.commit_target[5:0] - 6'd1] == term_q) begin
          commit_idx = r.commit_target;
          acc = 1'b1;
        end
      end
      CmdApply: begin
        n = 0;
        while (applied_idx < commit_idx && applied_idx < log_count && n < LogDepth) begin
          o = node_rsp(1'b1, applied_idx + 7'd1);
          o.out_event = log_event[applied_idx[5:0]];
          o.out_stamp = log_stamp[applied_idx[5:0]];
          o.out_kind = log_kind[applied_idx[5:0]];
          o.last = 1'b0;
          applied_idx++;
          queue_rsp(o);
          n++;
        end
        if (n == 0) queue_rsp(node_rsp(1'b0, applied_idx));
        else expected_rsp[$].last = 1'b1;
        return;
      end
      default: begin
        if (elapsed != 32'hffff_ffff) elapsed++;
        if (elec_max > elec_min) limit = elec_min + r.jitter % (elec_max - elec_min);
        else limit = elec_min;
        o = node_rsp(1'b0, commit_idx);
        o.heartbeat_expired = elapsed > hb_limit;
        o.election_expired = elapsed > limit;
        queue_rsp(o);
        return;
      end
    endcase
    queue_rsp(node_rsp(acc, commit_idx));
  endfunction

  task automatic check_field(string name, logic [63:0] exp, logic [63:0] got);
    if (exp !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp, got);
      fails_o++;
    end
  endtask

  task automatic check_rsp(rsp_t got);
    rsp_t e;
    if (expected_rsp.size() == 0) begin
      $display("%0t: unexpected response, expected none, got %p", $time, got);
      fails_o++;
      return;
    end
    e = expected_rsp.pop_front();
    check_field("accepted", e.accepted, got.accepted);
    check_field("log_position", e.log_position, got.log_position);
    check_field("term_now", e.term_now, got.term_now);
    check_field("role", e.role, got.role);
    check_field("heartbeat_expired", e.heartbeat_expired, got.heartbeat_expired);
    check_field("election_expired", e.election_expired, got.election_expired);
    check_field("out_event", e.out_event, got.out_event);
    check_field("out_stamp", e.out_stamp, got.out_stamp);
    check_field("out_kind", e.out_kind, got.out_kind);
    check_field("last", e.last, got.last);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fails_o = 0;
      responses_o = 0;
      own_id = 4'd0;
      hb_limit = 16'd50;
      elec_min = 16'd150;
      elec_max = 16'd300;
      term_q = '0;
      voted_for = NoVote;
      role_q = RoleFollower;
      log_count = '0;
      commit_idx = '0;
      applied_idx = '0;
      elapsed = '0;
      expected_rsp.delete();
      pending_o = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        check_rsp(rsp.data);
        responses_o++;
      end
      if (req.valid && req.ready) advance_node(req.data);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgOwnNode: own_id = cfg_data_i[3:0];
          CfgHeartbeat: hb_limit = cfg_data_i;
          CfgElecMin: elec_min = cfg_data_i;
          CfgElecMax: elec_max = cfg_data_i;
          default: ;
        endcase
      end
      pending_o = expected_rsp.size();
    end
  end
endmodule

// ===== tb/sv/tb_raft_node_term_vote_log.sv =====
// testbench top for the raft node: stimulus, configuration phases and verdict
`timescale 1ns / 1ps
module tb_raft_node_term_vote_log;
  import rntvl_pkg::*;

  logic                clk_i, rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  int unsigned         fails, pending, responses, requests;
  logic [31:0]         node_term;
  logic [6:0]          node_log_count, node_commit;
  logic                calm;

  rntvl_req_if req ();
  rntvl_rsp_if rsp ();

  raft_node_term_vote_log DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .req(req), .rsp(rsp)
  );

  tb_raft_node_term_vote_log_chk u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .req(req), .rsp(rsp),
    .fails_o(fails), .pending_o(pending), .responses_o(responses),
    .term_o(node_term), .log_count_o(node_log_count), .commit_o(node_commit)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("tb_raft_node_term_vote_log NOT OK");
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rsp.ready <= 1'b0;
    else rsp.ready <= calm || ($urandom_range(99) >= 35);
  end

  function automatic req_t make_req(cmd_e c);
    req_t r;
    r.command = c;
    r.event_tag = $urandom;
    r.stamp_ms = 48'({$urandom, $urandom});
    r.entry_kind = 2'($urandom_range(3));
    case ($urandom_range(9))
      0: r.peer_term = $urandom;
      1: r.peer_term = node_term - $urandom_range(3);
      default: r.peer_term = node_term + $urandom_range(2);
    endcase
    r.peer_node = 4'($urandom_range(15));
    r.commit_target = ($urandom_range(3) == 0) ? 7'($urandom_range(64)) :
                      7'(node_commit + $urandom_range(node_log_count - node_commit));
    r.jitter = 10'($urandom_range(1023));
    return r;
  endfunction

  task automatic send_request(req_t r);
    logic hit;
    req.valid <= 1'b1;
    req.data <= r;
    do begin
      @(negedge clk_i);
      hit = req.ready;
      @(posedge clk_i);
    end while (!hit);
    requests++;
    if (!calm && $urandom_range(99) < 35) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic send_cmd(cmd_e c);
    send_request(make_req(c));
  endtask

  task automatic drain;
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_config(logic [3:0] own, logic [15:0] hb, logic [15:0] emin,
                            logic [15:0] emax);
    logic [CfgDataW-1:0] vals [4];
    vals = '{16'(own), hb, emin, emax};
    drain();
    foreach (vals[i]) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= CfgIdxW'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_burst(int n);
    int k;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(19))
        0, 1: send_cmd(CmdElect);
        2, 3: send_cmd(CmdLeader);
        4, 5, 6, 7, 8: send_cmd(CmdAppend);
        9, 10, 11: send_cmd(CmdCommit);
        12, 13: send_cmd(CmdApply);
        14, 15, 16: send_cmd(CmdTick);
        17: send_cmd(CmdVote);
        18: send_cmd(CmdHigher);
        default: send_request(req_t'(138'({$urandom, $urandom, $urandom, $urandom,
                                           $urandom})));
      endcase
    end
  endtask

  task automatic directed_part;
    req_t r;
    send_cmd(CmdAppend);
    send_cmd(CmdApply);
    r = make_req(CmdVote); r.peer_term = 0; r.peer_node = 4'd3; send_request(r);
    r.peer_node = 4'd5; send_request(r);
    r = make_req(CmdHigher); r.peer_term = 0; send_request(r);
    r.peer_term = 32'd5; send_request(r);
    send_cmd(CmdElect);
    send_cmd(CmdLeader);
    r = make_req(CmdAppend);
    r.event_tag = '1; r.stamp_ms = '1; r.entry_kind = 2'd3; send_request(r);
    r.event_tag = '0; r.stamp_ms = '0; r.entry_kind = 2'd0; send_request(r);
    send_cmd(CmdAppend);
    r = make_req(CmdCommit);
    r.commit_target = 7'd0; send_request(r);
    r.commit_target = 7'd64; send_request(r);
    r.commit_target = 7'd2; send_request(r);
    r.commit_target = 7'd1; send_request(r);
    send_cmd(CmdApply);
    r.commit_target = 7'd3; send_request(r);
    send_cmd(CmdApply);
    send_cmd(CmdApply);
    r = make_req(CmdVote); r.peer_term = 32'd1; send_request(r);
    r = make_req(CmdTick); r.jitter = 10'h3ff; send_request(r);
    r.jitter = 10'h0; send_request(r);
  endtask

  initial begin
    int k;
    rst_ni = 1'b0;
    calm = 1'b0;
    requests = 0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgOwnNode;
    cfg_data_i = '0;
    req.valid = 1'b0;
    req.data = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_part();
    random_burst(100);
    set_config(4'd0, 16'd0, 16'd0, 16'd0);
    random_burst(60);
    set_config(4'd15, 16'hffff, 16'hffff, 16'hffff);
    calm = 1'b1;
    random_burst(60);
    calm = 1'b0;
    set_config(4'd7, 16'd2, 16'd3, 16'd9);
    random_burst(120);
    drain();
    set_config(4'($urandom), 16'($urandom_range(8)), 16'($urandom_range(12)),
               16'($urandom_range(40)));
    random_burst(120);

    // fill the log and apply one long run
    send_cmd(CmdElect);
    send_cmd(CmdLeader);
    for (k = 0; k < 68; k++) send_cmd(CmdAppend);
    begin
      req_t r;
      r = make_req(CmdCommit); r.commit_target = 7'd64; send_request(r);
      send_cmd(CmdApply);
      r = make_req(CmdHigher); r.peer_term = '1; send_request(r);
      send_cmd(CmdElect);
      r = make_req(CmdVote); r.peer_term = '1; r.peer_node = 4'd15; send_request(r);
      send_cmd(CmdTick);
    end
    drain();

    $display("covered %0d requests and %0d responses over five register settings,",
             requests, responses);
    $display("including a full log, a maximal apply walk and a saturated term");
    if (fails == 0) $display("tb_raft_node_term_vote_log OK");
    else $display("tb_raft_node_term_vote_log NOT OK");
    $finish;
  end
endmodule

// ===== filelist.f =====
hw/rtl/rntvl_pkg.sv
hw/rtl/rntvl_req_if.sv
hw/rtl/rntvl_front.sv
hw/rtl/rntvl_back.sv
hw/rtl/raft_node_term_vote_log.sv
hw/rtl/rntvl_checker.sv
tb/sv/tb_raft_node_term_vote_log_chk.sv
tb/sv/tb_raft_node_term_vote_log.sv
